// File: hw/rtl/bit_plane_pixel_array_alu_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bit-plane pixel array ALU
// Shared property forms, all clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BIT_PLANE_PIXEL_ARRAY_ALU_DEFINES_SVH
`define BIT_PLANE_PIXEL_ARRAY_ALU_DEFINES_SVH

// same-cycle implication
`define BPPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bppa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bppa_pkg
// Types and constants shared by the pixel array ALU, its cells and control.
// ---------------------------------------------------------------------------
package bppa_pkg;

    localparam int KIND_W  = 5;
    localparam int IDX_W   = 3;
    localparam int OFF_W   = 4;
    localparam int PLANE_W = 64;

    typedef enum logic [KIND_W-1:0] {
        K_OR2    = 5'd0,
        K_OR3    = 5'd1,
        K_OR4    = 5'd2,
        K_NOR2   = 5'd3,
        K_NOR3   = 5'd4,
        K_NOR4   = 5'd5,
        K_NOT    = 5'd6,
        K_AND    = 5'd7,
        K_NAND   = 5'd8,
        K_IMP    = 5'd9,
        K_NIMP   = 5'd10,
        K_XOR    = 5'd11,
        K_MOV    = 5'd12,
        K_MUX    = 5'd13,
        K_CLR_IF = 5'd14,
        K_SHIFT  = 5'd15,
        K_LOAD   = 5'd16
    } t_kind;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        SL_A   = 3'd0,
        SL_B   = 3'd1,
        SL_C   = 3'd2,
        SL_D   = 3'd3,
        SL_M   = 3'd4,
        SL_OLD = 3'd5
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_CAP   = 3'd2,
        ST_CALC  = 3'd3,
        ST_SHIFT = 3'd4,
        ST_WRITE = 3'd5
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic               use_mask;
        logic               cap_en;
        t_slot              cap_slot;
        logic               cap_ok;
        logic               calc;
        logic               step;
        logic               pull_next;
        logic               fill;
        logic               hshift;
        logic               take_larger;
        logic [OFF_W-1:0]   hoff;
        logic               we;
    } t_cell_ctl;

endpackage

// File: hw/rtl/bppa_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bppa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bppa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bppa_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bppa_cell
// One pixel row: its slice of every plane, operand latches, row ALU and a
// working row that moves to a neighbor cell on each vertical shift step.
// ---------------------------------------------------------------------------
module bppa_cell
    import bppa_pkg::*;
#(
    parameter int COLS   = 8,
    parameter int PLANES = 8,
    localparam int PW    = (PLANES > 1) ? $clog2(PLANES) : 1
) (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [PW-1:0]   i_raddr,
    input  logic [PW-1:0]   i_waddr,
    input  logic [COLS-1:0] i_load_row,
    input  logic [COLS-1:0] i_from_prev,
    input  logic [COLS-1:0] i_from_next,
    output logic [COLS-1:0] o_row
);

    logic [COLS-1:0]   rdata;
    logic [COLS-1:0]   r_a, r_b, r_c, r_d, r_m, r_o;
    logic [COLS-1:0]   r_w;
    logic [COLS-1:0]   n_w;
    logic [COLS-1:0]   cap_val;
    logic [COLS-1:0]   fillv;
    logic [COLS-1:0]   hs;
    logic [COLS-1:0]   res;
    logic [2*COLS-1:0] wide_r;
    logic [2*COLS-1:0] wide_l;

    bppa_ram #(
        .W     (COLS),
        .DEPTH (PLANES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_waddr),
        .i_wdata (r_w),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    assign cap_val = i_ctl.cap_ok ? rdata : '0;
    assign fillv   = {COLS{i_ctl.fill}};
    assign wide_r  = {fillv, r_a} >> i_ctl.hoff;
    assign wide_l  = {r_a, fillv} << i_ctl.hoff;

    always_comb begin
        if (32'(i_ctl.hoff) >= COLS) begin
            hs = fillv;
        end else if (i_ctl.take_larger) begin
            hs = wide_r[COLS-1:0];
        end else begin
            hs = wide_l[2*COLS-1:COLS];
        end
    end

    always_comb begin
        case (i_ctl.kind)
            K_OR2:    res = r_a | r_b;
            K_OR3:    res = r_a | r_b | r_c;
            K_OR4:    res = r_a | r_b | r_c | r_d;
            K_NOR2:   res = ~(r_a | r_b);
            K_NOR3:   res = ~(r_a | r_b | r_c);
            K_NOR4:   res = ~(r_a | r_b | r_c | r_d);
            K_NOT:    res = ~r_a;
            K_AND:    res = r_a & r_b;
            K_NAND:   res = ~(r_a & r_b);
            K_IMP:    res = r_a | ~r_b;
            K_NIMP:   res = ~r_a & r_b;
            K_XOR:    res = r_a ^ r_b;
            K_MOV:    res = r_a;
            K_MUX:    res = (r_b & ~r_a) | (r_c & r_a);
            K_CLR_IF: res = r_o & ~r_a;
            K_SHIFT:  res = i_ctl.hshift ? hs : r_a;
            K_LOAD:   res = i_load_row;
            default:  res = r_o;
        endcase
    end

    always_comb begin
        if (i_ctl.calc) begin
            n_w = i_ctl.use_mask ? ((r_o & ~r_m) | (res & r_m)) : res;
        end else if (i_ctl.step) begin
            n_w = i_ctl.pull_next ? i_from_next : i_from_prev;
        end else begin
            n_w = r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (i_ctl.cap_en) begin
            case (i_ctl.cap_slot)
                SL_A:    r_a <= cap_val;
                SL_B:    r_b <= cap_val;
                SL_C:    r_c <= cap_val;
                SL_D:    r_d <= cap_val;
                SL_M:    r_m <= cap_val;
                SL_OLD:  r_o <= cap_val;
                default: r_o <= r_o;
            endcase
        end
    end

    assign o_row = r_w;

endmodule

// File: hw/rtl/bit_plane_pixel_array_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bit_plane_pixel_array_alu
// Bit-plane pixel array ALU: a column of row cells holding PLANES one-bit
// planes, executing one whole-plane instruction per item.
// ---------------------------------------------------------------------------
// Usage:
//  - Items enter on start while busy is low; the fields are taken at that
//    edge. busy stays high until the result strobe cycle.
//  - Each item gives one result: o_result_plane and o_written_index are
//    shown for exactly one cycle with o_result_strobe high. The receiver
//    cannot stall; a result not taken in that cycle is gone.
//  - An item steps through READ, CAP and CALC, then SHIFT for a north or
//    south shift by min(shift_offset, ROWS) rows, then WRITE. The six
//    operand planes are read one per cycle through each cell's single RAM
//    read port, and a vertical shift moves the rows one cell per cycle.
//    A new item may be accepted in the strobe cycle.
//  - The user writes origin_corner on the cfg channel (always ready) only
//    while idle; the block itself does not enforce this.
//  - Reset clears the control, origin_corner and the per-plane valid bits,
//    so every plane reads as zero until written. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "bit_plane_pixel_array_alu_defines.svh"

module bit_plane_pixel_array_alu
    import bppa_pkg::*;
#(
    parameter int ROWS   = 8,
    parameter int COLS   = 8,
    parameter int PLANES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [IDX_W-1:0]   i_dst_plane,
    input  logic [IDX_W-1:0]   i_src_a,
    input  logic [IDX_W-1:0]   i_src_b,
    input  logic [IDX_W-1:0]   i_src_c,
    input  logic [IDX_W-1:0]   i_src_d,
    input  logic [IDX_W-1:0]   i_mask_plane,
    input  logic               i_masked,
    input  logic [1:0]         i_direction,
    input  logic [OFF_W-1:0]   i_shift_offset,
    input  logic               i_fill_bit,
    input  logic [PLANE_W-1:0] i_load_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data,
    output logic               o_result_strobe,
    output logic [PLANE_W-1:0] o_result_plane,
    output logic [IDX_W-1:0]   o_written_index
);

    localparam int PW  = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int PIX = ROWS * COLS;

    t_state             r_state, n_state;
    t_slot              r_slot, n_slot;
    logic               r_cap_en, n_cap_en;
    t_slot              r_cap_slot, n_cap_slot;
    logic               r_cap_ok, n_cap_ok;
    logic [OFF_W-1:0]   r_steps, n_steps;
    logic [PLANES-1:0]  r_valid;
    logic [1:0]         r_origin;
    logic               r_strobe, n_strobe;
    logic [PLANE_W-1:0] r_res;
    logic [IDX_W-1:0]   r_widx;

    logic [KIND_W-1:0]  r_kind;
    logic [IDX_W-1:0]   r_dst, r_a, r_b, r_c, r_d, r_mi;
    logic               r_masked;
    t_dir               r_dir;
    logic [OFF_W-1:0]   r_off;
    logic               r_fill;
    logic [PLANE_W-1:0] r_load;

    logic [IDX_W-1:0]   rd_idx;
    logic               rd_ok;
    logic               dst_ok;
    logic               kind_ok;
    logic               vertical;
    logic               bottom, right;
    logic [OFF_W-1:0]   vsteps;
    logic               accept;
    t_cell_ctl          ctl;
    logic [PW-1:0]      raddr, waddr;
    logic [PIX-1:0]     plane_bits;
    logic [COLS-1:0]    rows [ROWS];

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign bottom      = r_origin[1];
    assign right       = r_origin[0];
    assign vertical    = (r_dir == DIR_NORTH) || (r_dir == DIR_SOUTH);
    assign kind_ok     = (r_kind <= KIND_W'(K_LOAD));
    assign dst_ok      = (32'(r_dst) < PLANES);
    assign vsteps      = (32'(r_off) >= ROWS) ? OFF_W'(ROWS) : r_off;

    always_comb begin
        case (r_slot)
            SL_A:    rd_idx = r_a;
            SL_B:    rd_idx = r_b;
            SL_C:    rd_idx = r_c;
            SL_D:    rd_idx = r_d;
            SL_M:    rd_idx = r_mi;
            SL_OLD:  rd_idx = r_dst;
            default: rd_idx = r_dst;
        endcase
    end

    assign rd_ok = (32'(rd_idx) < PLANES) && r_valid[PW'(rd_idx)];
    assign raddr = PW'(rd_idx);
    assign waddr = PW'(r_dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slot     <= SL_A;
            r_cap_en   <= 1'b0;
            r_cap_slot <= SL_A;
            r_cap_ok   <= 1'b0;
            r_steps    <= '0;
            r_valid    <= '0;
            r_origin   <= 2'd0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_cap_en   <= n_cap_en;
            r_cap_slot <= n_cap_slot;
            r_cap_ok   <= n_cap_ok;
            r_steps    <= n_steps;
            r_strobe   <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_origin <= i_cfg_data;
            end
            if (ctl.we) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_dst    <= i_dst_plane;
            r_a      <= i_src_a;
            r_b      <= i_src_b;
            r_c      <= i_src_c;
            r_d      <= i_src_d;
            r_mi     <= i_mask_plane;
            r_masked <= i_masked;
            r_dir    <= t_dir'(i_direction);
            r_off    <= i_shift_offset;
            r_fill   <= i_fill_bit;
            r_load   <= i_load_value;
        end
        if (r_state == ST_WRITE) begin
            r_res  <= PLANE_W'(plane_bits);
            r_widx <= r_dst;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_cap_en   = 1'b0;
        n_cap_slot = r_slot;
        n_cap_ok   = rd_ok;
        n_steps    = r_steps;
        n_strobe   = 1'b0;

        ctl.kind        = t_kind'(r_kind);
        ctl.use_mask    = r_masked && kind_ok && (r_kind != KIND_W'(K_SHIFT));
        ctl.cap_en      = r_cap_en;
        ctl.cap_slot    = r_cap_slot;
        ctl.cap_ok      = r_cap_ok;
        ctl.calc        = 1'b0;
        ctl.step        = 1'b0;
        ctl.pull_next   = (r_dir == DIR_NORTH) ? !bottom : bottom;
        ctl.fill        = r_fill;
        ctl.hshift      = !vertical;
        ctl.take_larger = (r_dir == DIR_EAST) ? !right : right;
        ctl.hoff        = r_off;
        ctl.we          = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                    n_slot  = SL_A;
                end
            end
            ST_READ: begin
                n_cap_en = 1'b1;
                case (r_slot)
                    SL_A:    n_slot = SL_B;
                    SL_B:    n_slot = SL_C;
                    SL_C:    n_slot = SL_D;
                    SL_D:    n_slot = SL_M;
                    SL_M:    n_slot = SL_OLD;
                    default: n_state = ST_CAP;
                endcase
            end
            ST_CAP: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                ctl.calc = 1'b1;
                if ((r_kind == KIND_W'(K_SHIFT)) && vertical && (vsteps != '0)) begin
                    n_state = ST_SHIFT;
                    n_steps = vsteps;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_SHIFT: begin
                ctl.step = 1'b1;
                n_steps  = r_steps - 1'b1;
                if (r_steps == OFF_W'(1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ctl.we   = kind_ok && dst_ok;
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < ROWS; g++) begin : g_row
        logic [COLS-1:0] from_prev;
        logic [COLS-1:0] from_next;

        if (g == 0) begin : g_first
            assign from_prev = {COLS{r_fill}};
        end else begin : g_mid_prev
            assign from_prev = rows[g-1];
        end
        if (g == ROWS - 1) begin : g_last
            assign from_next = {COLS{r_fill}};
        end else begin : g_mid_next
            assign from_next = rows[g+1];
        end

        bppa_cell #(
            .COLS   (COLS),
            .PLANES (PLANES)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_raddr     (raddr),
            .i_waddr     (waddr),
            .i_load_row  (r_load[g*COLS +: COLS]),
            .i_from_prev (from_prev),
            .i_from_next (from_next),
            .o_row       (rows[g])
        );

        assign plane_bits[g*COLS +: COLS] = rows[g];
    end

    assign o_result_strobe = r_strobe;
    assign o_result_plane  = r_res;
    assign o_written_index = r_widx;

    `BPPA_ASSERT_NOW(a_strobe_idle, o_result_strobe, !busy, "result strobe while busy")
    `BPPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `BPPA_ASSERT_NEXT(a_strobe_single, o_result_strobe, !o_result_strobe, "strobe held two cycles")
    `BPPA_ASSERT_NOW(a_shift_count, r_state == ST_SHIFT, r_steps != '0, "shift with zero steps left")
    `BPPA_ASSERT_NEXT(a_write_strobe, r_state == ST_WRITE, o_result_strobe, "write without result strobe")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit-plane pixel array ALU testbench
// Runs a directed table and then random instruction streams under all four
// origin corners. A local plane file predicts each destination plane and
// index, and every result strobe is checked in order against that prediction.
// ---------------------------------------------------------------------------
module tb
    import bppa_pkg::*;
();

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int PLANES      = 8;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 350;
    localparam int N_ROWS_DIR  = 27;
    localparam logic [KIND_W-1:0]  KIND_UNDEF_LO = 5'd17;
    localparam logic [KIND_W-1:0]  KIND_UNDEF_HI = 5'd31;
    localparam logic [PLANE_W-1:0] ALL_ONES      = '1;
    localparam logic [PLANE_W-1:0] ALL_ZEROS     = '0;
    localparam logic [PLANE_W-1:0] PATTERN       = 64'h0123_4567_89ab_cdef;
    localparam logic [PLANE_W-1:0] CORNER_BITS   = 64'h8000_0000_0000_0001;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   dst;
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        logic [IDX_W-1:0]   c;
        logic [IDX_W-1:0]   d;
        logic [IDX_W-1:0]   m;
        logic               masked;
        t_dir               dir;
        logic [OFF_W-1:0]   off;
        logic               fill;
        logic [PLANE_W-1:0] val;
    } t_instr;

    typedef struct {
        t_instr             ins;
        bit                 typed;
        logic [PLANE_W-1:0] want;
    } t_stim_row;

    typedef struct {
        logic [PLANE_W-1:0] plane;
        logic [IDX_W-1:0]   idx;
    } t_plane_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [KIND_W-1:0]  i_kind = '0;
    logic [IDX_W-1:0]   i_dst_plane = '0;
    logic [IDX_W-1:0]   i_src_a = '0;
    logic [IDX_W-1:0]   i_src_b = '0;
    logic [IDX_W-1:0]   i_src_c = '0;
    logic [IDX_W-1:0]   i_src_d = '0;
    logic [IDX_W-1:0]   i_mask_plane = '0;
    logic               i_masked = 1'b0;
    logic [1:0]         i_direction = '0;
    logic [OFF_W-1:0]   i_shift_offset = '0;
    logic               i_fill_bit = 1'b0;
    logic [PLANE_W-1:0] i_load_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_data = '0;
    logic               o_result_strobe;
    logic [PLANE_W-1:0] o_result_plane;
    logic [IDX_W-1:0]   o_written_index;

    logic [PLANE_W-1:0] plane_model [PLANES];
    logic [1:0]         origin_model = '0;
    t_plane_result      planes_due [$];
    t_plane_result      due_now;
    t_stim_row          stim_rows [N_ROWS_DIR];
    logic [1:0]         phase_origin [N_PHASES] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
    int                 errors = 0;
    int                 n_sent = 0;
    int                 n_checked = 0;
    int                 n_cfg = 0;

    bit_plane_pixel_array_alu #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .PLANES (PLANES)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_dst_plane     (i_dst_plane),
        .i_src_a         (i_src_a),
        .i_src_b         (i_src_b),
        .i_src_c         (i_src_c),
        .i_src_d         (i_src_d),
        .i_mask_plane    (i_mask_plane),
        .i_masked        (i_masked),
        .i_direction     (i_direction),
        .i_shift_offset  (i_shift_offset),
        .i_fill_bit      (i_fill_bit),
        .i_load_value    (i_load_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result_plane  (o_result_plane),
        .o_written_index (o_written_index)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [PLANE_W-1:0] shift_plane(input logic [PLANE_W-1:0] src,
                                                       input int dr, input int dc,
                                                       input logic fill);
        logic [PLANE_W-1:0] res;
        int                 sr;
        int                 sc;
        res = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                sr = r + dr;
                sc = c + dc;
                if (sr < 0 || sr >= ROWS || sc < 0 || sc >= COLS) begin
                    res[r*COLS+c] = fill;
                end else begin
                    res[r*COLS+c] = src[sr*COLS+sc];
                end
            end
        end
        return res;
    endfunction

    function automatic t_plane_result apply_instr(input t_instr ins);
        logic [PLANE_W-1:0] pa;
        logic [PLANE_W-1:0] pb;
        logic [PLANE_W-1:0] pc;
        logic [PLANE_W-1:0] pd;
        logic [PLANE_W-1:0] pm;
        logic [PLANE_W-1:0] old;
        logic [PLANE_W-1:0] res;
        logic               wr;
        logic               use_m;
        int                 k;
        int                 dr;
        int                 dc;
        t_plane_result      out;
        pa    = plane_model[ins.a];
        pb    = plane_model[ins.b];
        pc    = plane_model[ins.c];
        pd    = plane_model[ins.d];
        pm    = plane_model[ins.m];
        old   = plane_model[ins.dst];
        res   = old;
        wr    = 1'b1;
        use_m = ins.masked;
        k     = int'(ins.off);
        dr    = 0;
        dc    = 0;
        case (ins.kind)
            K_OR2:    res = pa | pb;
            K_OR3:    res = pa | pb | pc;
            K_OR4:    res = pa | pb | pc | pd;
            K_NOR2:   res = ~(pa | pb);
            K_NOR3:   res = ~(pa | pb | pc);
            K_NOR4:   res = ~(pa | pb | pc | pd);
            K_NOT:    res = ~pa;
            K_AND:    res = pa & pb;
            K_NAND:   res = ~(pa & pb);
            K_IMP:    res = pa | ~pb;
            K_NIMP:   res = ~pa & pb;
            K_XOR:    res = pa ^ pb;
            K_MOV:    res = pa;
            K_MUX:    res = (pb & ~pa) | (pc & pa);
            K_CLR_IF: res = old & ~pa;
            K_SHIFT: begin
                use_m = 1'b0;
                case (ins.dir)
                    DIR_NORTH: dr = origin_model[1] ? -k : k;
                    DIR_SOUTH: dr = origin_model[1] ? k : -k;
                    DIR_EAST:  dc = origin_model[0] ? -k : k;
                    default:   dc = origin_model[0] ? k : -k;
                endcase
                res = shift_plane(pa, dr, dc, ins.fill);
            end
            K_LOAD:   res = ins.val;
            default: begin
                wr    = 1'b0;
                use_m = 1'b0;
            end
        endcase
        if (use_m) begin
            res = (old & ~pm) | (res & pm);
        end
        if (wr) begin
            plane_model[ins.dst] = res;
        end
        out.plane = res;
        out.idx   = ins.dst;
        return out;
    endfunction

    function automatic t_instr mk(input logic [KIND_W-1:0] kind, input int dst, input int a,
                                  input int b, input int c, input int d, input int m,
                                  input logic masked, input t_dir dir, input int off,
                                  input logic fill, input logic [PLANE_W-1:0] val);
        t_instr ins;
        ins.kind   = kind;
        ins.dst    = IDX_W'(dst);
        ins.a      = IDX_W'(a);
        ins.b      = IDX_W'(b);
        ins.c      = IDX_W'(c);
        ins.d      = IDX_W'(d);
        ins.m      = IDX_W'(m);
        ins.masked = masked;
        ins.dir    = dir;
        ins.off    = OFF_W'(off);
        ins.fill   = fill;
        ins.val    = val;
        return ins;
    endfunction

    function automatic t_instr rand_instr();
        t_instr ins;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            ins.kind = KIND_W'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
        end else if (r < 22) begin
            ins.kind = K_LOAD;
        end else if (r < 40) begin
            ins.kind = K_SHIFT;
        end else begin
            ins.kind = KIND_W'($urandom_range(K_OR2, K_CLR_IF));
        end
        ins.dst    = IDX_W'($urandom_range(0, PLANES - 1));
        ins.a      = IDX_W'($urandom_range(0, PLANES - 1));
        ins.b      = IDX_W'($urandom_range(0, PLANES - 1));
        ins.c      = IDX_W'($urandom_range(0, PLANES - 1));
        ins.d      = IDX_W'($urandom_range(0, PLANES - 1));
        ins.m      = IDX_W'($urandom_range(0, PLANES - 1));
        ins.masked = 1'($urandom_range(0, 1));
        ins.dir    = t_dir'($urandom_range(0, 3));
        ins.off    = OFF_W'($urandom_range(0, 99) < 85 ? $urandom_range(0, 8)
                                                       : $urandom_range(9, 15));
        ins.fill   = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 10) begin
            ins.val = ALL_ONES;
        end else if (r < 15) begin
            ins.val = ALL_ZEROS;
        end else if (r < 25) begin
            ins.val = ALL_ZEROS;
            ins.val[$urandom_range(0, PLANE_W - 1)] = 1'b1;
        end else begin
            ins.val = {$urandom, $urandom};
        end
        return ins;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input t_instr ins, input bit typed, input logic [PLANE_W-1:0] want,
                         input int gap);
        t_plane_result r;
        start          <= 1'b1;
        i_kind         <= ins.kind;
        i_dst_plane    <= ins.dst;
        i_src_a        <= ins.a;
        i_src_b        <= ins.b;
        i_src_c        <= ins.c;
        i_src_d        <= ins.d;
        i_mask_plane   <= ins.m;
        i_masked       <= ins.masked;
        i_direction    <= ins.dir;
        i_shift_offset <= ins.off;
        i_fill_bit     <= ins.fill;
        i_load_value   <= ins.val;
        do @(posedge i_clk); while (busy);
        r = apply_instr(ins);
        if (typed) begin
            r.plane = want;
        end
        planes_due.push_back(r);
        n_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (planes_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_origin(input logic [1:0] corner);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= corner;
        do @(posedge i_clk); while (!o_cfg_ready);
        origin_model = corner;
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (planes_due.size() == 0) begin
                $error("unexpected result: written_index %0d result_plane %h",
                       o_written_index, o_result_plane);
                errors++;
            end else begin
                due_now = planes_due.pop_front();
                n_checked++;
                if (o_result_plane !== due_now.plane) begin
                    $error("result_plane: expected %h, actual %h",
                           due_now.plane, o_result_plane);
                    errors++;
                end
                if (o_written_index !== due_now.idx) begin
                    $error("written_index: expected %0d, actual %0d",
                           due_now.idx, o_written_index);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        bit burst;
        for (int p = 0; p < PLANES; p++) begin
            plane_model[p] = '0;
        end
        stim_rows[0]  = '{mk(K_OR2, 0, 1, 2, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 1, ALL_ZEROS};
        stim_rows[1]  = '{mk(K_NOR4, 1, 0, 2, 3, 4, 0, 0, DIR_NORTH, 0, 0, '0), 1, ALL_ONES};
        stim_rows[2]  = '{mk(K_LOAD, 2, 0, 0, 0, 0, 0, 0, DIR_NORTH, 0, 0, ALL_ONES), 1,
                          ALL_ONES};
        stim_rows[3]  = '{mk(K_LOAD, 3, 0, 0, 0, 0, 0, 0, DIR_NORTH, 0, 0, PATTERN), 1,
                          PATTERN};
        stim_rows[4]  = '{mk(K_LOAD, 4, 0, 0, 0, 0, 0, 0, DIR_NORTH, 0, 0, CORNER_BITS), 1,
                          CORNER_BITS};
        stim_rows[5]  = '{mk(K_LOAD, 0, 0, 0, 0, 0, 3, 1, DIR_NORTH, 0, 0, ALL_ONES), 1,
                          PATTERN};
        stim_rows[6]  = '{mk(K_LOAD, 7, 0, 0, 0, 0, 0, 0, DIR_NORTH, 0, 0, ALL_ZEROS), 1,
                          ALL_ZEROS};
        stim_rows[7]  = '{mk(K_OR3, 5, 4, 0, 7, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[8]  = '{mk(K_OR4, 6, 4, 0, 7, 1, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[9]  = '{mk(K_NOR2, 5, 0, 4, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[10] = '{mk(K_NOR3, 6, 0, 4, 7, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[11] = '{mk(K_NOT, 7, 3, 0, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[12] = '{mk(K_AND, 5, 3, 1, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[13] = '{mk(K_NAND, 6, 3, 7, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[14] = '{mk(K_IMP, 5, 4, 3, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[15] = '{mk(K_NIMP, 6, 4, 3, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[16] = '{mk(K_XOR, 5, 3, 4, 0, 0, 4, 1, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[17] = '{mk(K_MOV, 6, 3, 0, 0, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[18] = '{mk(K_MUX, 7, 4, 3, 1, 0, 0, 0, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[19] = '{mk(K_CLR_IF, 0, 4, 0, 0, 0, 1, 1, DIR_NORTH, 0, 0, '0), 0, '0};
        stim_rows[20] = '{mk(K_SHIFT, 5, 3, 0, 0, 0, 7, 1, DIR_NORTH, 0, 1, '0), 1, PATTERN};
        stim_rows[21] = '{mk(K_SHIFT, 6, 4, 0, 0, 0, 0, 0, DIR_EAST, 8, 1, '0), 1, ALL_ONES};
        stim_rows[22] = '{mk(K_SHIFT, 7, 2, 0, 0, 0, 0, 0, DIR_SOUTH, 15, 0, '0), 1,
                          ALL_ZEROS};
        stim_rows[23] = '{mk(K_SHIFT, 5, 3, 0, 0, 0, 0, 0, DIR_WEST, 1, 1, '0), 0, '0};
        stim_rows[24] = '{mk(K_SHIFT, 6, 3, 0, 0, 0, 2, 1, DIR_NORTH, 3, 0, '0), 0, '0};
        stim_rows[25] = '{mk(KIND_UNDEF_HI, 2, 0, 0, 0, 0, 0, 1, DIR_NORTH, 0, 0, '0), 1,
                          ALL_ONES};
        stim_rows[26] = '{mk(KIND_UNDEF_LO, 0, 1, 2, 3, 4, 5, 0, DIR_NORTH, 0, 0, ALL_ONES), 0,
                          '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            issue(stim_rows[i].ins, stim_rows[i].typed, stim_rows[i].want,
                  $urandom_range(0, 2));
        end

        burst = 1'b0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_origin(phase_origin[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 64 == 0) begin
                    burst = ($urandom_range(0, 99) < 30);
                end
                issue(rand_instr(), 1'b0, '0, burst ? 0 : pick_gap());
            end
        end

        drain();
        repeat (30) @(posedge i_clk);

        $display("Issued %0d plane instructions (%0d directed) across %0d origin writes,",
                 n_sent, N_ROWS_DIR, n_cfg);
        $display("covering every op, masking, shifts to offset 15, undefined kinds; %0d checked.",
                 n_checked);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bppa_pkg.sv
hw/rtl/bppa_ram.sv
hw/rtl/bppa_cell.sv
hw/rtl/bit_plane_pixel_array_alu.sv
tb/tb.sv
